@@ design/steg_pkg.sv @@
// Package for the sine tone envelope generator: widths, register codes, state
// and status types, and the quarter-wave sine table built at elaboration.
// Depends on nothing; every design file imports it.
`default_nettype none

package steg_pkg;

  // Core sizing
  localparam int PHASE_BITS    = 16;
  localparam int TABLE_BITS    = 10;
  localparam int ENV_FRAC_BITS = 8;

  // Fixed field widths
  localparam int PHASE_STEP_W = 16;
  localparam int AMP_W        = 11;
  localparam int ENV_STEP_W   = 9;
  localparam int DAC_W        = 12;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int SINE_FRAC    = 11;

  // Derived sizes
  localparam int ENV_W       = ENV_FRAC_BITS + 1;
  localparam int ENV_FULL    = 1 << ENV_FRAC_BITS;
  localparam int ENV_T_W     = ENV_W + ENV_STEP_W + 1;
  localparam int QTR_LEN     = 1 << (TABLE_BITS - 2);
  localparam int HALF_LEN    = 1 << (TABLE_BITS - 1);
  localparam int QTR_IDX_W   = TABLE_BITS - 1;
  localparam int ENV_DIGITS  = (ENV_W + 1) / 2;
  localparam int SINE_DIGITS = (SINE_FRAC + 1) / 2;
  localparam int MAX_DIGITS  = (ENV_DIGITS > SINE_DIGITS) ? ENV_DIGITS : SINE_DIGITS;
  localparam int MPL_W       = 2 * MAX_DIGITS;
  localparam int DIG_CNT_W   = $clog2(MAX_DIGITS);
  localparam int PROD_W      = AMP_W + ENV_W + SINE_FRAC;
  localparam int SCALE_SHIFT = SINE_FRAC + ENV_FRAC_BITS;
  localparam int DEV_W       = PROD_W + 1 - SCALE_SHIFT;
  localparam int CODE_SUM_W  = ((DEV_W > DAC_W) ? DEV_W : DAC_W) + 2;
  localparam int DAC_MAX     = (1 << DAC_W) - 1;

  // Fixed-point sine series constants
  localparam int          Q_FRAC      = 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PHASE_STEP    = 2'd0,
    REG_AMPLITUDE     = 2'd1,
    REG_ENVELOPE_STEP = 2'd2,
    REG_MIDPOINT      = 2'd3
  } cfg_reg_t;

  // Scaling sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL_ENV,
    ST_MUL_SINE,
    ST_DONE
  } steg_state_t;

  // Status from the scaling unit to the top level
  typedef struct packed {
    logic busy;
    logic done;
  } steg_status_t;

  typedef logic [QTR_LEN:0][SINE_FRAC-1:0] qtr_tab_t;

  // Q0.11 sine of quarter-wave position k (Taylor series in Q30, terms to x^13)
  function automatic logic [SINE_FRAC-1:0] quarter_sine(input int unsigned k);
    logic [63:0] x;
    logic [63:0] term;
    longint      sum;
    logic [63:0] v;
    x    = (64'(k) * HALF_PI_Q30) >> (TABLE_BITS - 2);
    term = x;
    sum  = longint'(x);
    for (int n = 1; n <= 6; n++) begin
      term = (term * x) >> Q_FRAC;
      term = (term * x) >> Q_FRAC;
      term = term / 64'((2 * n) * (2 * n + 1));
      if ((n % 2) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    v = (64'(sum) + (64'd1 << (Q_FRAC - SINE_FRAC - 1))) >> (Q_FRAC - SINE_FRAC);
    if (v > 64'((1 << SINE_FRAC) - 1)) begin
      v = 64'((1 << SINE_FRAC) - 1);
    end
    return v[SINE_FRAC-1:0];
  endfunction

  function automatic qtr_tab_t build_qtr_table();
    qtr_tab_t t;
    for (int k = 0; k <= QTR_LEN; k++) begin
      t[k] = quarter_sine(k);
    end
    return t;
  endfunction

  localparam qtr_tab_t QTR_TABLE = build_qtr_table();

endpackage

`default_nettype wire

@@ design/steg_scale.sv @@
// Digit-serial scaling unit: |sine| * amplitude * envelope, two bits a cycle,
// then floor shift, midpoint offset and saturation. Depends on steg_pkg.
`default_nettype none

module steg_scale import steg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [AMP_W-1:0]     amplitude,
  input  logic [ENV_W-1:0]     env_level,
  input  logic [SINE_FRAC-1:0] sine_mag,
  input  logic                 sine_neg,
  input  logic [DAC_W-1:0]     midpoint,
  input  logic                 out_free,
  output steg_status_t         status,
  output logic [DAC_W-1:0]     code
);

  steg_state_t            state_r, state_nxt;
  logic [DIG_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [PROD_W-1:0]      mcand_r, mcand_nxt;
  logic [MPL_W-1:0]       mplier_r, mplier_nxt;
  logic [PROD_W-1:0]      acc_r, acc_nxt;
  logic [SINE_FRAC-1:0]   sine_r, sine_nxt;
  logic                   neg_r, neg_nxt;

  logic [1:0]             digit;
  logic [PROD_W-1:0]      pp;
  logic [PROD_W-1:0]      acc_step;
  logic [PROD_W:0]        rnd;
  logic [DEV_W-1:0]       dev;
  logic signed [CODE_SUM_W-1:0] code_sum;

  // One radix-4 digit of the multiplier per cycle
  assign digit    = mplier_r[1:0];
  assign pp       = (digit[0] ? mcand_r : '0) +
                    (digit[1] ? {mcand_r[PROD_W-2:0], 1'b0} : '0);
  assign acc_step = acc_r + pp;

  // Floor toward minus infinity: round the magnitude up when negative
  assign rnd = {1'b0, acc_r} +
               (neg_r ? (PROD_W+1)'((64'd1 << SCALE_SHIFT) - 64'd1) : '0);
  assign dev = rnd[PROD_W -: DEV_W];

  always_comb begin
    if (neg_r) begin
      code_sum = $signed(CODE_SUM_W'(midpoint)) - $signed(CODE_SUM_W'(dev));
    end else begin
      code_sum = $signed(CODE_SUM_W'(midpoint)) + $signed(CODE_SUM_W'(dev));
    end
  end

  // Saturate to the DAC range
  always_comb begin
    if (code_sum < 0) begin
      code = '0;
    end else if (code_sum > $signed(CODE_SUM_W'(DAC_MAX))) begin
      code = DAC_W'(DAC_MAX);
    end else begin
      code = code_sum[DAC_W-1:0];
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    acc_r    <= acc_nxt;
    sine_r   <= sine_nxt;
    neg_r    <= neg_nxt;
  end

  // Next state and datapath control
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    mcand_nxt   = mcand_r;
    mplier_nxt  = mplier_r;
    acc_nxt     = acc_r;
    sine_nxt    = sine_r;
    neg_nxt     = neg_r;
    status.busy = (state_r != ST_IDLE);
    status.done = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          mcand_nxt  = PROD_W'(amplitude);
          mplier_nxt = MPL_W'(env_level);
          acc_nxt    = '0;
          sine_nxt   = sine_mag;
          neg_nxt    = sine_neg;
          cnt_nxt    = '0;
          state_nxt  = ST_MUL_ENV;
        end
      end
      ST_MUL_ENV: begin
        if (cnt_r == DIG_CNT_W'(ENV_DIGITS - 1)) begin
          // amplitude * envelope becomes the multiplicand of the sine pass
          mcand_nxt  = acc_step;
          mplier_nxt = MPL_W'(sine_r);
          acc_nxt    = '0;
          cnt_nxt    = '0;
          state_nxt  = ST_MUL_SINE;
        end else begin
          acc_nxt    = acc_step;
          mcand_nxt  = {mcand_r[PROD_W-3:0], 2'b00};
          mplier_nxt = {2'b00, mplier_r[MPL_W-1:2]};
          cnt_nxt    = cnt_r + 1'b1;
        end
      end
      ST_MUL_SINE: begin
        acc_nxt    = acc_step;
        mcand_nxt  = {mcand_r[PROD_W-3:0], 2'b00};
        mplier_nxt = {2'b00, mplier_r[MPL_W-1:2]};
        if (cnt_r == DIG_CNT_W'(SINE_DIGITS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
        end
      end
      ST_DONE: begin
        // hold the code until the output register is free
        if (out_free) begin
          status.done = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ design/sine_tone_envelope_generator.sv @@
// A silent beat (enable low) loads the midpoint into the output register at accept.
// A tone beat runs the digit pass of amplitude * envelope, then that of the sine
// product, then shifts, offsets and saturates the result and loads the output
// register once it is free. The two-bit-a-cycle scaling multiplier takes no new
// beat until it has handed over its code and returned to idle.
// Reset (synchronous, rst_n low): phase and envelope cleared, registers to defaults.
`default_nettype none

module sine_tone_envelope_generator import steg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_enable,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DAC_W-1:0]      out_dac_code,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [PHASE_STEP_W-1:0] phase_step_r;
  logic [AMP_W-1:0]        amplitude_r;
  logic [ENV_STEP_W-1:0]   env_step_r;
  logic [DAC_W-1:0]        midpoint_r;

  logic [PHASE_BITS-1:0]   phase_r;
  logic [ENV_W-1:0]        env_level_r, env_level_nxt;
  logic                    env_falling_r, env_falling_nxt;
  logic                    out_valid_r;
  logic [DAC_W-1:0]        out_code_r;

  logic                    out_free;
  logic                    accept;
  logic                    tone_start;
  steg_status_t            scale_status;
  logic [DAC_W-1:0]        scale_code;

  logic signed [ENV_T_W-1:0] env_sum;
  logic [TABLE_BITS-1:0]   tab_idx;
  logic [QTR_IDX_W-1:0]    half_pos;
  logic [QTR_IDX_W-1:0]    qtr_pos;
  logic [SINE_FRAC-1:0]    sine_mag;

  // Handshake
  assign out_free     = !out_valid_r || out_ready;
  assign in_ready     = !scale_status.busy && out_free;
  assign accept       = in_valid && in_ready;
  assign tone_start   = accept && in_enable;
  assign out_valid    = out_valid_r;
  assign out_dac_code = out_code_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r <= PHASE_STEP_W'(3604);
      amplitude_r  <= AMP_W'(1800);
      env_step_r   <= ENV_STEP_W'(256);
      midpoint_r   <= DAC_W'(2048);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PHASE_STEP:    phase_step_r <= cfg_wdata[PHASE_STEP_W-1:0];
        REG_AMPLITUDE:     amplitude_r  <= cfg_wdata[AMP_W-1:0];
        REG_ENVELOPE_STEP: env_step_r   <= cfg_wdata[ENV_STEP_W-1:0];
        REG_MIDPOINT:      midpoint_r   <= cfg_wdata[DAC_W-1:0];
        default: ;
      endcase
    end
  end

  // Triangle envelope: step, clamp at full scale, then clamp at zero
  always_comb begin
    if (env_falling_r) begin
      env_sum = $signed(ENV_T_W'(env_level_r)) - $signed(ENV_T_W'(env_step_r));
    end else begin
      env_sum = $signed(ENV_T_W'(env_level_r)) + $signed(ENV_T_W'(env_step_r));
    end
    env_level_nxt   = env_sum[ENV_W-1:0];
    env_falling_nxt = env_falling_r;
    if (env_sum >= $signed(ENV_T_W'(ENV_FULL))) begin
      env_level_nxt   = ENV_W'(ENV_FULL);
      env_falling_nxt = 1'b1;
    end else if (env_sum <= 0) begin
      env_level_nxt   = '0;
      env_falling_nxt = 1'b0;
    end
  end

  // Sine lookup: mirror within the half wave, sign from the top bit
  assign tab_idx  = phase_r[PHASE_BITS-1 -: TABLE_BITS];
  assign half_pos = tab_idx[QTR_IDX_W-1:0];
  always_comb begin
    if (32'(half_pos) <= QTR_LEN) begin
      qtr_pos = half_pos;
    end else begin
      qtr_pos = QTR_IDX_W'(TABLE_BITS'(HALF_LEN) - {1'b0, half_pos});
    end
  end
  assign sine_mag = QTR_TABLE[qtr_pos];

  // Advance phase and envelope on each tone beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= '0;
      env_level_r   <= '0;
      env_falling_r <= 1'b0;
    end else if (tone_start) begin
      phase_r       <= phase_r + PHASE_BITS'(phase_step_r);
      env_level_r   <= env_level_nxt;
      env_falling_r <= env_falling_nxt;
    end
  end

  steg_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (tone_start),
    .amplitude (amplitude_r),
    .env_level (env_level_nxt),
    .sine_mag  (sine_mag),
    .sine_neg  (tab_idx[TABLE_BITS-1]),
    .midpoint  (midpoint_r),
    .out_free  (out_free),
    .status    (scale_status),
    .code      (scale_code)
  );

  // Output register: silent beats load the midpoint, tone beats the scaled code
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((accept && !in_enable) || scale_status.done) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !in_enable) begin
      out_code_r <= midpoint_r;
    end else if (scale_status.done) begin
      out_code_r <= scale_code;
    end
  end

endmodule

`default_nettype wire

@@ design/steg_checker.sv @@
// Port-level checker for the sine tone envelope generator, bound to the top.
// Depends on steg_pkg for widths.
`default_nettype none

module steg_checker import steg_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  in_enable,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [DAC_W-1:0]      out_dac_code
);

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output beat valid after reset");

  // A stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_dac_code)))
    else $error("stalled output beat changed");

  // A silent beat lands in the output register on the next cycle
  a_silent_next: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !in_enable) |=> out_valid)
    else $error("silent beat produced no output");

  // A tone beat keeps the input closed while it is scaled
  a_tone_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_enable) |=> !in_ready)
    else $error("input accepted during scaling");

  // No input is taken while a finished beat is stalled
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input accepted with output stalled");

endmodule

bind sine_tone_envelope_generator steg_checker u_steg_checker (.*);

`default_nettype wire
